>>> rtl/i2c_log_pkg.sv
// ----------------------------------------------------------------------------
// i2c_log_pkg
// Shared widths, operation codes, bus action codes and defaults for the
// I2C EEPROM log sequencer.
// ----------------------------------------------------------------------------
package i2c_log_pkg;

  localparam int OP_W    = 4;
  localparam int LINE_W  = 11;
  localparam int BYTE_W  = 8;
  localparam int INDEX_W = 4;
  localparam int ACT_W   = 3;
  localparam int POS_W   = 4;
  localparam int TICK_W  = 8;

  localparam int ENTRY_BYTES_DEF = 16;

  localparam logic [TICK_W-1:0] WAIT_TICKS_RESET = 8'd161;

  localparam logic [OP_W-1:0] OP_APPEND     = 4'd0;
  localparam logic [OP_W-1:0] OP_WRITE_LINE = 4'd1;
  localparam logic [OP_W-1:0] OP_READ_LINE  = 4'd2;
  localparam logic [OP_W-1:0] OP_LOAD_BYTE  = 4'd3;
  localparam logic [OP_W-1:0] OP_START_DONE = 4'd4;
  localparam logic [OP_W-1:0] OP_BYTE_SENT  = 4'd5;
  localparam logic [OP_W-1:0] OP_BYTE_READ  = 4'd6;
  localparam logic [OP_W-1:0] OP_STOP_DONE  = 4'd7;
  localparam logic [OP_W-1:0] OP_TICK       = 4'd8;

  localparam logic [ACT_W-1:0] ACT_NONE  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_START = 3'd1;
  localparam logic [ACT_W-1:0] ACT_WRITE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_READ  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_STOP  = 3'd4;

  localparam logic [BYTE_W-1:0] DEV_ADDR_WR = 8'ha0;
  localparam logic [BYTE_W-1:0] DEV_ADDR_RD = 8'ha1;
  localparam logic [BYTE_W-1:0] HI_MASK     = 8'h7f;
  localparam logic [BYTE_W-1:0] LO_MASK     = 8'hf0;

endpackage

>>> rtl/i2c_log_if.sv
// ----------------------------------------------------------------------------
// i2c_log_if
// Handshake channels of the log sequencer: bus events and commands in,
// bus actions and status out.
// ----------------------------------------------------------------------------
interface i2c_log_in_if;
  logic                                valid;
  logic                                ready;
  logic [i2c_log_pkg::OP_W-1:0]        operation;
  logic [i2c_log_pkg::LINE_W-1:0]      line;
  logic                                bus_ok;
  logic [i2c_log_pkg::BYTE_W-1:0]      byte_value;
  logic [i2c_log_pkg::INDEX_W-1:0]     byte_index;

  modport source (output valid, operation, line, bus_ok, byte_value, byte_index,
                  input ready);
  modport sink (input valid, operation, line, bus_ok, byte_value, byte_index,
                output ready);
endinterface

interface i2c_log_out_if;
  logic                                valid;
  logic                                ready;
  logic [i2c_log_pkg::ACT_W-1:0]       bus_action;
  logic [i2c_log_pkg::BYTE_W-1:0]      bus_byte;
  logic                                read_ack;
  logic                                accepted;
  logic                                read_valid;
  logic [i2c_log_pkg::POS_W-1:0]       read_position;
  logic [i2c_log_pkg::BYTE_W-1:0]      read_data;
  logic                                read_done;
  logic                                append_done;

  modport source (output valid, bus_action, bus_byte, read_ack, accepted, read_valid,
                  read_position, read_data, read_done, append_done,
                  input ready);
  modport sink (input valid, bus_action, bus_byte, read_ack, accepted, read_valid,
                read_position, read_data, read_done, append_done,
                output ready);
endinterface

>>> rtl/i2c_eeprom_log_sequencer.sv
// The result of an accepted transaction is registered in the output register.
// Throughput: one transaction per cycle unless the status output stalls; state update
// and result are one combinational pass; a new transaction enters as a result leaves.
// Reset: synchronous active-low rst_n returns to idle, clears the counters and line,
// and sets the write delay register to 161 ticks; the entry buffer is not reset.
// ----------------------------------------------------------------------------
// i2c_eeprom_log_sequencer
// Steps an I2C EEPROM page write or random read of one log entry, one bus
// event per transaction, with a tick-counted write delay after each write.
// ----------------------------------------------------------------------------
module i2c_eeprom_log_sequencer #(
  parameter int ENTRY_BYTES = i2c_log_pkg::ENTRY_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [i2c_log_pkg::TICK_W-1:0]    cfg_data,
  i2c_log_in_if.sink                        in_if,
  i2c_log_out_if.source                     out_if
);

  localparam int BUF_IDX_W = (ENTRY_BYTES > 1) ? $clog2(ENTRY_BYTES) : 1;
  localparam int CNT_W     = $clog2(ENTRY_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ENTRY_BYTES - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ENTRY_BYTES);
  localparam logic [i2c_log_pkg::INDEX_W:0] IDX_LIMIT =
    (i2c_log_pkg::INDEX_W + 1)'(ENTRY_BYTES);

  localparam int PH_W = 4;
  localparam logic [PH_W-1:0] PH_IDLE       = 4'd0;
  localparam logic [PH_W-1:0] PH_WR_START   = 4'd1;
  localparam logic [PH_W-1:0] PH_WR_DEV     = 4'd2;
  localparam logic [PH_W-1:0] PH_WR_HI      = 4'd3;
  localparam logic [PH_W-1:0] PH_WR_DATA    = 4'd4;
  localparam logic [PH_W-1:0] PH_WR_STOP    = 4'd5;
  localparam logic [PH_W-1:0] PH_RD_START   = 4'd6;
  localparam logic [PH_W-1:0] PH_RD_DEV     = 4'd7;
  localparam logic [PH_W-1:0] PH_RD_HI      = 4'd8;
  localparam logic [PH_W-1:0] PH_RD_LO      = 4'd9;
  localparam logic [PH_W-1:0] PH_RD_RESTART = 4'd10;
  localparam logic [PH_W-1:0] PH_RD_DEV2    = 4'd11;
  localparam logic [PH_W-1:0] PH_RD_DATA    = 4'd12;
  localparam logic [PH_W-1:0] PH_RD_STOP    = 4'd13;

  logic [PH_W-1:0]                        phase_r, phase_nxt;
  logic [CNT_W-1:0]                       count_r, count_nxt;
  logic [i2c_log_pkg::LINE_W-1:0]         target_r, target_nxt;
  logic [i2c_log_pkg::LINE_W-1:0]         next_line_r, next_line_nxt;
  logic [i2c_log_pkg::TICK_W-1:0]         wait_cnt_r, wait_cnt_nxt;
  logic                                   waiting_r, waiting_nxt;
  logic                                   append_r, append_nxt;
  logic [i2c_log_pkg::TICK_W-1:0]         wait_ticks_r;
  logic [i2c_log_pkg::BYTE_W-1:0]         entry_buf_r [ENTRY_BYTES];

  logic                                   out_valid_r;
  logic [i2c_log_pkg::ACT_W-1:0]          action_r, action_nxt;
  logic [i2c_log_pkg::BYTE_W-1:0]         bus_byte_r, bus_byte_nxt;
  logic                                   read_ack_r, read_ack_nxt;
  logic                                   accepted_r, accepted_nxt;
  logic                                   rd_valid_r, rd_valid_nxt;
  logic [i2c_log_pkg::POS_W-1:0]          rd_pos_r, rd_pos_nxt;
  logic [i2c_log_pkg::BYTE_W-1:0]         rd_data_r, rd_data_nxt;
  logic                                   rd_done_r, rd_done_nxt;
  logic                                   app_done_r, app_done_nxt;

  logic                                   in_fire;
  logic                                   load_en;
  logic [CNT_W-1:0]                       count_inc;
  logic [i2c_log_pkg::BYTE_W-1:0]         hi_addr;
  logic [i2c_log_pkg::BYTE_W-1:0]         lo_addr;
  logic [i2c_log_pkg::BYTE_W-1:0]         buf_rd;

  assign in_if.ready = ~out_valid_r | out_if.ready;
  assign in_fire     = in_if.valid & in_if.ready;

  assign load_en = in_fire && (in_if.operation == i2c_log_pkg::OP_LOAD_BYTE) &&
                   ({1'b0, in_if.byte_index} < IDX_LIMIT);

  assign count_inc = count_r + CNT_W'(1);
  assign hi_addr   = 8'(target_r >> 4) & i2c_log_pkg::HI_MASK;
  assign lo_addr   = 8'(target_r << 4) & i2c_log_pkg::LO_MASK;
  assign buf_rd    = entry_buf_r[BUF_IDX_W'(count_r)];

  always_comb begin
    phase_nxt     = phase_r;
    count_nxt     = count_r;
    target_nxt    = target_r;
    next_line_nxt = next_line_r;
    wait_cnt_nxt  = wait_cnt_r;
    waiting_nxt   = waiting_r;
    append_nxt    = append_r;
    action_nxt    = i2c_log_pkg::ACT_NONE;
    bus_byte_nxt  = '0;
    read_ack_nxt  = 1'b0;
    accepted_nxt  = 1'b0;
    rd_valid_nxt  = 1'b0;
    rd_pos_nxt    = '0;
    rd_data_nxt   = '0;
    rd_done_nxt   = 1'b0;
    app_done_nxt  = 1'b0;
    case (in_if.operation)
      i2c_log_pkg::OP_APPEND, i2c_log_pkg::OP_WRITE_LINE,
      i2c_log_pkg::OP_READ_LINE: begin
        if (phase_r == PH_IDLE && in_if.bus_ok) begin
          if (in_if.operation == i2c_log_pkg::OP_READ_LINE) begin
            target_nxt = in_if.line;
            phase_nxt  = PH_RD_START;
          end else if (in_if.operation == i2c_log_pkg::OP_APPEND) begin
            append_nxt = 1'b1;
            target_nxt = next_line_r + i2c_log_pkg::LINE_W'(1);
            phase_nxt  = PH_WR_START;
          end else begin
            append_nxt = 1'b0;
            target_nxt = in_if.line;
            phase_nxt  = PH_WR_START;
          end
          count_nxt    = '0;
          action_nxt   = i2c_log_pkg::ACT_START;
          accepted_nxt = 1'b1;
        end
      end
      i2c_log_pkg::OP_START_DONE: begin
        if (phase_r == PH_WR_START) begin
          phase_nxt    = PH_WR_DEV;
          action_nxt   = i2c_log_pkg::ACT_WRITE;
          bus_byte_nxt = i2c_log_pkg::DEV_ADDR_WR;
        end else if (phase_r == PH_RD_START) begin
          phase_nxt    = PH_RD_DEV;
          action_nxt   = i2c_log_pkg::ACT_WRITE;
          bus_byte_nxt = i2c_log_pkg::DEV_ADDR_WR;
        end else if (phase_r == PH_RD_RESTART) begin
          phase_nxt    = PH_RD_DEV2;
          action_nxt   = i2c_log_pkg::ACT_WRITE;
          bus_byte_nxt = i2c_log_pkg::DEV_ADDR_RD;
        end
      end
      i2c_log_pkg::OP_BYTE_SENT: begin
        if (!in_if.bus_ok) begin
          phase_nxt  = PH_IDLE;
          action_nxt = i2c_log_pkg::ACT_STOP;
        end else begin
          case (phase_r)
            PH_WR_DATA: begin
              if (count_r < CNT_FULL) begin
                action_nxt   = i2c_log_pkg::ACT_WRITE;
                bus_byte_nxt = buf_rd;
                count_nxt    = count_inc;
              end else begin
                phase_nxt  = PH_WR_STOP;
                count_nxt  = '0;
                action_nxt = i2c_log_pkg::ACT_STOP;
              end
            end
            PH_WR_DEV: begin
              phase_nxt    = PH_WR_HI;
              action_nxt   = i2c_log_pkg::ACT_WRITE;
              bus_byte_nxt = hi_addr;
            end
            PH_WR_HI: begin
              phase_nxt    = PH_WR_DATA;
              action_nxt   = i2c_log_pkg::ACT_WRITE;
              bus_byte_nxt = lo_addr;
            end
            PH_RD_DEV: begin
              phase_nxt    = PH_RD_HI;
              action_nxt   = i2c_log_pkg::ACT_WRITE;
              bus_byte_nxt = hi_addr;
            end
            PH_RD_HI: begin
              phase_nxt    = PH_RD_LO;
              action_nxt   = i2c_log_pkg::ACT_WRITE;
              bus_byte_nxt = lo_addr;
            end
            PH_RD_LO: begin
              phase_nxt  = PH_RD_RESTART;
              action_nxt = i2c_log_pkg::ACT_START;
            end
            PH_RD_DEV2: begin
              phase_nxt    = PH_RD_DATA;
              count_nxt    = '0;
              action_nxt   = i2c_log_pkg::ACT_READ;
              read_ack_nxt = (ENTRY_BYTES != 1);
            end
            default: begin
            end
          endcase
        end
      end
      i2c_log_pkg::OP_BYTE_READ: begin
        if (!in_if.bus_ok) begin
          phase_nxt  = PH_IDLE;
          action_nxt = i2c_log_pkg::ACT_STOP;
        end else if (phase_r == PH_RD_DATA) begin
          rd_valid_nxt = 1'b1;
          rd_pos_nxt   = i2c_log_pkg::POS_W'(count_r);
          rd_data_nxt  = in_if.byte_value;
          count_nxt    = count_inc;
          if (count_inc >= CNT_FULL) begin
            phase_nxt  = PH_RD_STOP;
            action_nxt = i2c_log_pkg::ACT_STOP;
          end else begin
            action_nxt   = i2c_log_pkg::ACT_READ;
            read_ack_nxt = (count_inc != CNT_LAST);
          end
        end
      end
      i2c_log_pkg::OP_STOP_DONE: begin
        phase_nxt = PH_IDLE;
        if (phase_r == PH_WR_STOP) begin
          if (append_r) begin
            next_line_nxt = next_line_r + i2c_log_pkg::LINE_W'(1);
          end
          append_nxt   = 1'b0;
          waiting_nxt  = 1'b1;
          wait_cnt_nxt = wait_ticks_r;
        end else if (phase_r == PH_RD_STOP) begin
          rd_done_nxt = 1'b1;
        end
      end
      i2c_log_pkg::OP_TICK: begin
        if (waiting_r) begin
          if (wait_cnt_r <= i2c_log_pkg::TICK_W'(1)) begin
            wait_cnt_nxt = '0;
            waiting_nxt  = 1'b0;
            app_done_nxt = 1'b1;
          end else begin
            wait_cnt_nxt = wait_cnt_r - i2c_log_pkg::TICK_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      count_r      <= '0;
      target_r     <= '0;
      next_line_r  <= '0;
      wait_cnt_r   <= '0;
      waiting_r    <= 1'b0;
      append_r     <= 1'b0;
      wait_ticks_r <= i2c_log_pkg::WAIT_TICKS_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        wait_ticks_r <= cfg_data;
      end
      if (in_fire) begin
        phase_r     <= phase_nxt;
        count_r     <= count_nxt;
        target_r    <= target_nxt;
        next_line_r <= next_line_nxt;
        wait_cnt_r  <= wait_cnt_nxt;
        waiting_r   <= waiting_nxt;
        append_r    <= append_nxt;
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      action_r   <= action_nxt;
      bus_byte_r <= bus_byte_nxt;
      read_ack_r <= read_ack_nxt;
      accepted_r <= accepted_nxt;
      rd_valid_r <= rd_valid_nxt;
      rd_pos_r   <= rd_pos_nxt;
      rd_data_r  <= rd_data_nxt;
      rd_done_r  <= rd_done_nxt;
      app_done_r <= app_done_nxt;
    end
    if (load_en) begin
      entry_buf_r[BUF_IDX_W'(in_if.byte_index)] <= in_if.byte_value;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.bus_action    = action_r;
  assign out_if.bus_byte      = bus_byte_r;
  assign out_if.read_ack      = read_ack_r;
  assign out_if.accepted      = accepted_r;
  assign out_if.read_valid    = rd_valid_r;
  assign out_if.read_position = rd_pos_r;
  assign out_if.read_data     = rd_data_r;
  assign out_if.read_done     = rd_done_r;
  assign out_if.append_done   = app_done_r;

endmodule

>>> verif/tb_i2c_eeprom_log_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_eeprom_log_sequencer
// Self-checking bench for the I2C EEPROM log sequencer. Commands and bus
// events are sent as transactions with bursty pacing while the status
// channel stalls on its own pattern. A behavioral copy of the sequencer
// predicts every status transaction, and each one is compared field by field.
// ----------------------------------------------------------------------------
module tb_i2c_eeprom_log_sequencer;

  localparam int ENTRY_N          = i2c_log_pkg::ENTRY_BYTES_DEF;
  localparam int RANDOM_ITEMS     = 1400;
  localparam int LONG_HOLD_CYCLES = 150;
  localparam int DRAIN_LIMIT      = 4000;

  localparam logic [i2c_log_pkg::OP_W-1:0] OP_UNUSED_LO = 4'd9;
  localparam logic [i2c_log_pkg::OP_W-1:0] OP_UNUSED_HI = 4'd15;

  typedef enum logic [3:0] {
    SEQ_IDLE, SEQ_WR_START, SEQ_WR_DEV, SEQ_WR_HI, SEQ_WR_DATA, SEQ_WR_STOP,
    SEQ_RD_START, SEQ_RD_DEV, SEQ_RD_HI, SEQ_RD_LO, SEQ_RD_RESTART, SEQ_RD_DEV2,
    SEQ_RD_DATA, SEQ_RD_STOP
  } seq_phase_t;

  typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_PERIODIC, RX_COIN} rx_mode_t;

  typedef struct packed {
    logic [i2c_log_pkg::OP_W-1:0]    operation;
    logic [i2c_log_pkg::LINE_W-1:0]  line;
    logic                            bus_ok;
    logic [i2c_log_pkg::BYTE_W-1:0]  byte_value;
    logic [i2c_log_pkg::INDEX_W-1:0] byte_index;
  } bus_event_t;

  typedef struct packed {
    logic [i2c_log_pkg::ACT_W-1:0]  bus_action;
    logic [i2c_log_pkg::BYTE_W-1:0] bus_byte;
    logic                           read_ack;
    logic                           accepted;
    logic                           read_valid;
    logic [i2c_log_pkg::POS_W-1:0]  read_position;
    logic [i2c_log_pkg::BYTE_W-1:0] read_data;
    logic                           read_done;
    logic                           append_done;
  } seq_status_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [i2c_log_pkg::TICK_W-1:0] cfg_data;

  i2c_log_in_if  in_if ();
  i2c_log_out_if out_if ();

  i2c_eeprom_log_sequencer i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_if    (in_if),
    .out_if   (out_if)
  );

  seq_phase_t                     seq_phase;
  logic [4:0]                     seq_count;
  logic [i2c_log_pkg::LINE_W-1:0] seq_target;
  logic [i2c_log_pkg::LINE_W-1:0] seq_next_line;
  logic [i2c_log_pkg::BYTE_W-1:0] seq_entry [ENTRY_N];
  logic [i2c_log_pkg::TICK_W-1:0] seq_wait_cnt;
  logic                           seq_waiting;
  logic                           seq_append;
  logic [i2c_log_pkg::TICK_W-1:0] seq_wait_ticks;

  seq_status_t pending_status [$];
  int          items_sent;
  int          mismatches;
  int          hold_requests;
  int          burst_left;

  function automatic seq_status_t predict_status(bus_event_t ev);
    seq_status_t rsp;
    seq_phase_t  prev_phase;
    rsp = '0;
    case (ev.operation)
      i2c_log_pkg::OP_APPEND, i2c_log_pkg::OP_WRITE_LINE, i2c_log_pkg::OP_READ_LINE: begin
        if (seq_phase == SEQ_IDLE && ev.bus_ok) begin
          if (ev.operation == i2c_log_pkg::OP_READ_LINE) begin
            seq_target = ev.line;
            seq_phase  = SEQ_RD_START;
          end else begin
            seq_append = (ev.operation == i2c_log_pkg::OP_APPEND);
            seq_target = seq_append ? i2c_log_pkg::LINE_W'(seq_next_line + 1) : ev.line;
            seq_phase  = SEQ_WR_START;
          end
          seq_count      = '0;
          rsp.bus_action = i2c_log_pkg::ACT_START;
          rsp.accepted   = 1'b1;
        end
      end
      i2c_log_pkg::OP_LOAD_BYTE: begin
        if (int'(ev.byte_index) < ENTRY_N) seq_entry[ev.byte_index] = ev.byte_value;
      end
      i2c_log_pkg::OP_START_DONE: begin
        case (seq_phase)
          SEQ_WR_START: begin
            seq_phase      = SEQ_WR_DEV;
            rsp.bus_action = i2c_log_pkg::ACT_WRITE;
            rsp.bus_byte   = i2c_log_pkg::DEV_ADDR_WR;
          end
          SEQ_RD_START: begin
            seq_phase      = SEQ_RD_DEV;
            rsp.bus_action = i2c_log_pkg::ACT_WRITE;
            rsp.bus_byte   = i2c_log_pkg::DEV_ADDR_WR;
          end
          SEQ_RD_RESTART: begin
            seq_phase      = SEQ_RD_DEV2;
            rsp.bus_action = i2c_log_pkg::ACT_WRITE;
            rsp.bus_byte   = i2c_log_pkg::DEV_ADDR_RD;
          end
          default: ;
        endcase
      end
      i2c_log_pkg::OP_BYTE_SENT: begin
        if (!ev.bus_ok) begin
          seq_phase      = SEQ_IDLE;
          rsp.bus_action = i2c_log_pkg::ACT_STOP;
        end else begin
          case (seq_phase)
            SEQ_WR_DATA: begin
              if (int'(seq_count) < ENTRY_N) begin
                rsp.bus_action = i2c_log_pkg::ACT_WRITE;
                rsp.bus_byte   = seq_entry[seq_count[3:0]];
                seq_count      = seq_count + 5'd1;
              end else begin
                seq_phase      = SEQ_WR_STOP;
                seq_count      = '0;
                rsp.bus_action = i2c_log_pkg::ACT_STOP;
              end
            end
            SEQ_WR_DEV, SEQ_RD_DEV: begin
              seq_phase      = (seq_phase == SEQ_WR_DEV) ? SEQ_WR_HI : SEQ_RD_HI;
              rsp.bus_action = i2c_log_pkg::ACT_WRITE;
              rsp.bus_byte   = {1'b0, seq_target[10:4]};
            end
            SEQ_WR_HI, SEQ_RD_HI: begin
              seq_phase      = (seq_phase == SEQ_WR_HI) ? SEQ_WR_DATA : SEQ_RD_LO;
              rsp.bus_action = i2c_log_pkg::ACT_WRITE;
              rsp.bus_byte   = {seq_target[3:0], 4'h0};
            end
            SEQ_RD_LO: begin
              seq_phase      = SEQ_RD_RESTART;
              rsp.bus_action = i2c_log_pkg::ACT_START;
            end
            SEQ_RD_DEV2: begin
              seq_phase      = SEQ_RD_DATA;
              seq_count      = '0;
              rsp.bus_action = i2c_log_pkg::ACT_READ;
              rsp.read_ack   = (ENTRY_N != 1);
            end
            default: ;
          endcase
        end
      end
      i2c_log_pkg::OP_BYTE_READ: begin
        if (!ev.bus_ok) begin
          seq_phase      = SEQ_IDLE;
          rsp.bus_action = i2c_log_pkg::ACT_STOP;
        end else if (seq_phase == SEQ_RD_DATA) begin
          rsp.read_valid    = 1'b1;
          rsp.read_position = seq_count[3:0];
          rsp.read_data     = ev.byte_value;
          seq_count         = seq_count + 5'd1;
          if (int'(seq_count) >= ENTRY_N) begin
            seq_phase      = SEQ_RD_STOP;
            rsp.bus_action = i2c_log_pkg::ACT_STOP;
          end else begin
            rsp.bus_action = i2c_log_pkg::ACT_READ;
            rsp.read_ack   = (int'(seq_count) != ENTRY_N - 1);
          end
        end
      end
      i2c_log_pkg::OP_STOP_DONE: begin
        prev_phase = seq_phase;
        seq_phase  = SEQ_IDLE;
        if (prev_phase == SEQ_WR_STOP) begin
          if (seq_append) seq_next_line = seq_next_line + i2c_log_pkg::LINE_W'(1);
          seq_append   = 1'b0;
          seq_waiting  = 1'b1;
          seq_wait_cnt = seq_wait_ticks;
        end else if (prev_phase == SEQ_RD_STOP) begin
          rsp.read_done = 1'b1;
        end
      end
      i2c_log_pkg::OP_TICK: begin
        if (seq_waiting) begin
          if (seq_wait_cnt <= i2c_log_pkg::TICK_W'(1)) begin
            seq_wait_cnt    = '0;
            seq_waiting     = 1'b0;
            rsp.append_done = 1'b1;
          end else begin
            seq_wait_cnt = seq_wait_cnt - i2c_log_pkg::TICK_W'(1);
          end
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  task automatic send_event(logic [i2c_log_pkg::OP_W-1:0] op,
                            logic [i2c_log_pkg::LINE_W-1:0] line, logic ok,
                            logic [i2c_log_pkg::BYTE_W-1:0] val,
                            logic [i2c_log_pkg::INDEX_W-1:0] idx);
    bus_event_t ev;
    ev = '{operation: op, line: line, bus_ok: ok, byte_value: val, byte_index: idx};
    in_if.valid      <= 1'b1;
    in_if.operation  <= op;
    in_if.line       <= line;
    in_if.bus_ok     <= ok;
    in_if.byte_value <= val;
    in_if.byte_index <= idx;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    pending_status.push_back(predict_status(ev));
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  task automatic send_bus_event(logic [i2c_log_pkg::OP_W-1:0] op, logic ok);
    send_event(op, i2c_log_pkg::LINE_W'($urandom), ok, i2c_log_pkg::BYTE_W'($urandom),
               i2c_log_pkg::INDEX_W'($urandom));
  endtask

  task automatic send_noise();
    send_bus_event(i2c_log_pkg::OP_W'($urandom_range(0, 15)), ($urandom_range(0, 3) != 0));
  endtask

  // Walks one write or read transfer event by event. A bus fault can be
  // injected at one step, and random noise transactions can be mixed in.
  task automatic run_transfer(logic [i2c_log_pkg::OP_W-1:0] cmd,
                              logic [i2c_log_pkg::LINE_W-1:0] line,
                              int fault_at, int noise_pct);
    logic [i2c_log_pkg::OP_W-1:0] step_op;
    int                           n_steps;
    n_steps = (cmd == i2c_log_pkg::OP_READ_LINE) ? 23 : 21;
    send_event(cmd, line, 1'b1, i2c_log_pkg::BYTE_W'($urandom),
               i2c_log_pkg::INDEX_W'($urandom));
    for (int k = 0; k < n_steps; k++) begin
      if ($urandom_range(0, 99) < noise_pct) send_noise();
      if (k == n_steps - 1) step_op = i2c_log_pkg::OP_STOP_DONE;
      else if (k == 0 || (cmd == i2c_log_pkg::OP_READ_LINE && k == 4))
        step_op = i2c_log_pkg::OP_START_DONE;
      else if (cmd == i2c_log_pkg::OP_READ_LINE && k >= 6) step_op = i2c_log_pkg::OP_BYTE_READ;
      else step_op = i2c_log_pkg::OP_BYTE_SENT;
      if (k == fault_at && (step_op == i2c_log_pkg::OP_BYTE_SENT ||
                            step_op == i2c_log_pkg::OP_BYTE_READ)) begin
        send_bus_event(step_op, 1'b0);
        if ($urandom_range(0, 1) == 1) send_bus_event(i2c_log_pkg::OP_STOP_DONE, 1'b1);
        return;
      end
      send_bus_event(step_op, 1'b1);
    end
  endtask

  task automatic drain_status(int limit);
    int waited;
    waited = 0;
    in_if.valid <= 1'b0;
    while (pending_status.size() != 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
    repeat (3) @(posedge clk);
  endtask

  task automatic set_write_wait(logic [i2c_log_pkg::TICK_W-1:0] ticks);
    drain_status(DRAIN_LIMIT);
    cfg_we   <= 1'b1;
    cfg_data <= ticks;
    @(posedge clk);
    cfg_we <= 1'b0;
    seq_wait_ticks = ticks;
  endtask

  task automatic test_idle_events();
    send_bus_event(i2c_log_pkg::OP_TICK, 1'b1);
    send_bus_event(i2c_log_pkg::OP_STOP_DONE, 1'b1);
    send_bus_event(i2c_log_pkg::OP_START_DONE, 1'b1);
    send_bus_event(i2c_log_pkg::OP_BYTE_SENT, 1'b1);
    send_event(i2c_log_pkg::OP_BYTE_READ, '1, 1'b1, '1, '1);
    send_bus_event(i2c_log_pkg::OP_BYTE_SENT, 1'b0);
    send_bus_event(i2c_log_pkg::OP_BYTE_READ, 1'b0);
    send_event(OP_UNUSED_LO, '1, 1'b1, '1, '1);
    send_event(OP_UNUSED_HI, '1, 1'b1, '1, '1);
    send_event(i2c_log_pkg::OP_APPEND, '0, 1'b0, '0, '0);
    send_event(i2c_log_pkg::OP_WRITE_LINE, '1, 1'b0, '1, '1);
    send_event(i2c_log_pkg::OP_READ_LINE, '0, 1'b0, '0, '0);
  endtask

  task automatic test_entry_load();
    logic [i2c_log_pkg::BYTE_W-1:0] val;
    for (int i = 0; i < ENTRY_N; i++) begin
      if (i == 0) val = '0;
      else if (i == ENTRY_N - 1) val = '1;
      else val = i2c_log_pkg::BYTE_W'($urandom);
      send_event(i2c_log_pkg::OP_LOAD_BYTE, i2c_log_pkg::LINE_W'($urandom),
                 ($urandom_range(0, 1) == 1), val, i2c_log_pkg::INDEX_W'(i));
    end
  endtask

  task automatic test_busy_and_fault();
    send_event(i2c_log_pkg::OP_WRITE_LINE, '0, 1'b1, '0, '0);
    send_event(i2c_log_pkg::OP_APPEND, '1, 1'b1, '1, '1);
    send_event(i2c_log_pkg::OP_READ_LINE, '1, 1'b1, '1, '1);
    send_bus_event(i2c_log_pkg::OP_START_DONE, 1'b1);
    send_bus_event(i2c_log_pkg::OP_START_DONE, 1'b1);
    send_bus_event(i2c_log_pkg::OP_BYTE_READ, 1'b1);
    send_bus_event(i2c_log_pkg::OP_BYTE_SENT, 1'b0);
    send_bus_event(i2c_log_pkg::OP_STOP_DONE, 1'b1);
  endtask

  task automatic test_write_delay();
    set_write_wait(8'd1);
    run_transfer(i2c_log_pkg::OP_WRITE_LINE, '1, -1, 0);
    send_bus_event(i2c_log_pkg::OP_TICK, 1'b1);
    // A programmed delay of zero behaves like a single tick.
    set_write_wait('0);
    run_transfer(i2c_log_pkg::OP_WRITE_LINE, '0, -1, 0);
    send_bus_event(i2c_log_pkg::OP_TICK, 1'b0);
    // A second write stop while the delay runs restarts it.
    set_write_wait(8'd3);
    run_transfer(i2c_log_pkg::OP_APPEND, i2c_log_pkg::LINE_W'($urandom), -1, 0);
    send_bus_event(i2c_log_pkg::OP_TICK, 1'b1);
    run_transfer(i2c_log_pkg::OP_APPEND, i2c_log_pkg::LINE_W'($urandom), -1, 0);
    repeat (3) send_bus_event(i2c_log_pkg::OP_TICK, 1'b1);
  endtask

  task automatic test_read_line();
    run_transfer(i2c_log_pkg::OP_READ_LINE, 11'h555, -1, 0);
    run_transfer(i2c_log_pkg::OP_READ_LINE, 11'h2aa, 12, 0);
    send_bus_event(i2c_log_pkg::OP_STOP_DONE, 1'b1);
  endtask

  task automatic test_random_traffic();
    logic [i2c_log_pkg::TICK_W-1:0] setting [4];
    int                             phase_start;
    int                             sel;
    int                             fault_at;
    setting[0] = 8'd255;
    setting[1] = i2c_log_pkg::TICK_W'($urandom_range(2, 254));
    setting[2] = 8'd1;
    setting[3] = i2c_log_pkg::WAIT_TICKS_RESET;
    for (int p = 0; p < 4; p++) begin
      set_write_wait(setting[p]);
      // Starve the status channel for a while so the sequencer backs up.
      if (p == 1) hold_requests++;
      phase_start = items_sent;
      while (items_sent - phase_start < RANDOM_ITEMS / 4) begin
        sel      = $urandom_range(0, 99);
        fault_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 21) : -1;
        if (sel < 35) begin
          run_transfer(($urandom_range(0, 1) == 1) ? i2c_log_pkg::OP_APPEND :
                       i2c_log_pkg::OP_WRITE_LINE,
                       i2c_log_pkg::LINE_W'($urandom), fault_at, 5);
        end else if (sel < 65) begin
          run_transfer(i2c_log_pkg::OP_READ_LINE, i2c_log_pkg::LINE_W'($urandom), fault_at, 5);
        end else if (sel < 80) begin
          repeat (($urandom_range(0, 1) == 1) ? $urandom_range(1, 8) : int'(seq_wait_ticks) + 1)
            send_bus_event(i2c_log_pkg::OP_TICK, ($urandom_range(0, 1) == 1));
        end else if (sel < 90) begin
          repeat ($urandom_range(1, 6)) send_bus_event(i2c_log_pkg::OP_LOAD_BYTE, 1'b1);
        end else begin
          repeat ($urandom_range(1, 4)) send_noise();
        end
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin : result_receiver
    rx_mode_t mode;
    int       mode_left;
    int       holds_done;
    int       cycle_cnt;
    mode       = RX_ALWAYS;
    mode_left  = 0;
    holds_done = 0;
    cycle_cnt  = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        holds_done = hold_requests;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 160);
      end
      mode_left--;
      cycle_cnt++;
      case (mode)
        RX_ALWAYS:   out_if.ready <= 1'b1;
        RX_MOSTLY:   out_if.ready <= ($urandom_range(0, 3) != 0);
        RX_PERIODIC: out_if.ready <= (cycle_cnt % 5 != 0);
        default:     out_if.ready <= ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  always @(posedge clk) begin : status_check
    seq_status_t exp_status;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_status.size() == 0) begin
        $error("Status transaction arrived with none outstanding");
        mismatches++;
      end else begin
        exp_status = pending_status.pop_front();
        check_field("bus_action", 32'(exp_status.bus_action), 32'(out_if.bus_action));
        check_field("bus_byte", 32'(exp_status.bus_byte), 32'(out_if.bus_byte));
        check_field("read_ack", 32'(exp_status.read_ack), 32'(out_if.read_ack));
        check_field("accepted", 32'(exp_status.accepted), 32'(out_if.accepted));
        check_field("read_valid", 32'(exp_status.read_valid), 32'(out_if.read_valid));
        check_field("read_position", 32'(exp_status.read_position),
                    32'(out_if.read_position));
        check_field("read_data", 32'(exp_status.read_data), 32'(out_if.read_data));
        check_field("read_done", 32'(exp_status.read_done), 32'(out_if.read_done));
        check_field("append_done", 32'(exp_status.append_done), 32'(out_if.append_done));
      end
    end
  end

  initial begin
    seq_phase      = SEQ_IDLE;
    seq_count      = '0;
    seq_target     = '0;
    seq_next_line  = '0;
    seq_wait_cnt   = '0;
    seq_waiting    = 1'b0;
    seq_append     = 1'b0;
    seq_wait_ticks = i2c_log_pkg::WAIT_TICKS_RESET;
    items_sent     = 0;
    mismatches     = 0;
    hold_requests  = 0;
    burst_left     = 0;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_data         <= '0;
    in_if.valid      <= 1'b0;
    in_if.operation  <= '0;
    in_if.line       <= '0;
    in_if.bus_ok     <= 1'b0;
    in_if.byte_value <= '0;
    in_if.byte_index <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_events();
    test_entry_load();
    test_busy_and_fault();
    test_write_delay();
    test_read_line();
    test_random_traffic();
    drain_status(DRAIN_LIMIT);
    if (pending_status.size() != 0) begin
      $error("%0d status transactions never arrived", pending_status.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/i2c_log_pkg.sv
rtl/i2c_log_if.sv
rtl/i2c_eeprom_log_sequencer.sv
verif/tb_i2c_eeprom_log_sequencer.sv
